FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include guarded
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/esdp_pkg.sv
// shared types and constants of the es descriptor parser
// no dependencies
`timescale 1ns / 1ps

package esdp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // result kinds
  localparam logic [2:0] KIND_STREAM_ID = 3'd0;
  localparam logic [2:0] KIND_OBJ_TYPE  = 3'd1;
  localparam logic [2:0] KIND_INFO_LEN  = 3'd2;
  localparam logic [2:0] KIND_INFO_BYTE = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // error codes
  localparam logic [27:0] ERR_ES_TAG    = 28'd0;
  localparam logic [27:0] ERR_URL       = 28'd1;
  localparam logic [27:0] ERR_DC_TAG    = 28'd2;
  localparam logic [27:0] ERR_DSI_TAG   = 28'd3;
  localparam logic [27:0] ERR_TRUNCATED = 28'd4;

  // register indexes
  localparam logic [1:0] REG_ES_TAG  = 2'd0;
  localparam logic [1:0] REG_DC_TAG  = 2'd1;
  localparam logic [1:0] REG_DSI_TAG = 2'd2;

  localparam logic [7:0] RST_ES_TAG  = 8'd3;
  localparam logic [7:0] RST_DC_TAG  = 8'd4;
  localparam logic [7:0] RST_DSI_TAG = 8'd5;

  // bytes skipped between object type and specific info tag, minus one
  localparam logic [3:0] SKIP_LAST = 4'd11;
  // a size field holds at most four bytes
  localparam logic [1:0] SIZE_LAST = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] value;
    logic        last;
  } res_t;

  // one or two results caused by a single request
  typedef struct packed {
    logic pair;
    res_t r0;
    res_t r1;
  } grp_t;

  typedef struct packed {
    logic [7:0] es;
    logic [7:0] dc;
    logic [7:0] dsi;
  } tags_t;

endpackage

FILE: rtl/esdp_core.sv
// byte parser state machine: one request per cycle while take is high, up to two results
// depends on esdp_pkg
`timescale 1ns / 1ps

module esdp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_end_of_data,
  input  esdp_pkg::tags_t     tags,
  output logic                push,
  output esdp_pkg::grp_t      push_grp
);

  localparam logic [3:0] PH_ES_TAG   = 4'd0;
  localparam logic [3:0] PH_ES_SIZE  = 4'd1;
  localparam logic [3:0] PH_ID_HI    = 4'd2;
  localparam logic [3:0] PH_ID_LO    = 4'd3;
  localparam logic [3:0] PH_FLAGS    = 4'd4;
  localparam logic [3:0] PH_DEP_HI   = 4'd5;
  localparam logic [3:0] PH_DEP_LO   = 4'd6;
  localparam logic [3:0] PH_OCR_HI   = 4'd7;
  localparam logic [3:0] PH_OCR_LO   = 4'd8;
  localparam logic [3:0] PH_DC_TAG   = 4'd9;
  localparam logic [3:0] PH_DC_SIZE  = 4'd10;
  localparam logic [3:0] PH_OBJ      = 4'd11;
  localparam logic [3:0] PH_SKIP     = 4'd12;
  localparam logic [3:0] PH_DSI_TAG  = 4'd13;
  localparam logic [3:0] PH_DSI_SIZE = 4'd14;
  localparam logic [3:0] PH_INFO     = 4'd15;

  logic [3:0]  phase_r, phase_nxt;
  logic [27:0] size_r, size_nxt;
  logic [1:0]  size_cnt_r, size_cnt_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [3:0]  skip_r, skip_nxt;
  logic [27:0] info_r, info_nxt;
  logic        fin_r, fin_nxt;

  logic [27:0]    size_step;
  logic           size_done;
  logic           p_valid;
  esdp_pkg::res_t p_res;
  esdp_pkg::res_t e_res;
  logic           e_valid;

  // next phase after the flags byte or an optional id
  function automatic logic [3:0] after_opt(input logic [1:0] f);
    logic [3:0] ph;
    if (f[1]) ph = PH_DEP_HI;
    else if (f[0]) ph = PH_OCR_HI;
    else ph = PH_DC_TAG;
    return ph;
  endfunction

  assign size_step = {size_r[20:0], in_byte[6:0]};
  assign size_done = !in_byte[7] || (size_cnt_r == esdp_pkg::SIZE_LAST);

  always_comb begin
    phase_nxt    = phase_r;
    size_nxt     = size_r;
    size_cnt_nxt = size_cnt_r;
    flags_nxt    = flags_r;
    hold_nxt     = hold_r;
    skip_nxt     = skip_r;
    info_nxt     = info_r;
    fin_nxt      = fin_r;
    p_valid      = 1'b0;
    p_res        = '0;

    if (!fin_r) begin
      case (phase_r)
        PH_ES_TAG, PH_DC_TAG, PH_DSI_TAG: begin
          if ((phase_r == PH_ES_TAG && in_byte != tags.es) ||
              (phase_r == PH_DC_TAG && in_byte != tags.dc) ||
              (phase_r == PH_DSI_TAG && in_byte != tags.dsi)) begin
            p_valid = 1'b1;
            p_res.kind = esdp_pkg::KIND_ERROR;
            p_res.last = 1'b1;
            if (phase_r == PH_ES_TAG) p_res.value = esdp_pkg::ERR_ES_TAG;
            else if (phase_r == PH_DC_TAG) p_res.value = esdp_pkg::ERR_DC_TAG;
            else p_res.value = esdp_pkg::ERR_DSI_TAG;
            fin_nxt = 1'b1;
          end else begin
            size_nxt     = '0;
            size_cnt_nxt = '0;
            phase_nxt    = phase_r + 4'd1;
          end
        end
        PH_ES_SIZE, PH_DC_SIZE, PH_DSI_SIZE: begin
          size_nxt = size_step;
          if (!size_done) size_cnt_nxt = size_cnt_r + 2'd1;
          if (size_done) begin
            if (phase_r == PH_DSI_SIZE) begin
              info_nxt   = size_step;
              p_valid    = 1'b1;
              p_res.kind = esdp_pkg::KIND_INFO_LEN;
              p_res.value = size_step;
              if (size_step == '0) begin
                p_res.last = 1'b1;
                fin_nxt    = 1'b1;
              end else begin
                phase_nxt = PH_INFO;
              end
            end else begin
              phase_nxt = phase_r + 4'd1;
            end
          end
        end
        PH_ID_HI: begin
          hold_nxt  = in_byte;
          phase_nxt = PH_ID_LO;
        end
        PH_ID_LO: begin
          p_valid     = 1'b1;
          p_res.kind  = esdp_pkg::KIND_STREAM_ID;
          p_res.value = {12'd0, hold_r, in_byte};
          phase_nxt   = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (in_byte[6]) begin
            p_valid     = 1'b1;
            p_res.kind  = esdp_pkg::KIND_ERROR;
            p_res.value = esdp_pkg::ERR_URL;
            p_res.last  = 1'b1;
            fin_nxt     = 1'b1;
          end else begin
            flags_nxt = {in_byte[7], in_byte[5]};
            phase_nxt = after_opt({in_byte[7], in_byte[5]});
          end
        end
        PH_DEP_HI: phase_nxt = PH_DEP_LO;
        PH_DEP_LO: begin
          flags_nxt = {1'b0, flags_r[0]};
          phase_nxt = after_opt({1'b0, flags_r[0]});
        end
        PH_OCR_HI: phase_nxt = PH_OCR_LO;
        PH_OCR_LO: begin
          flags_nxt = '0;
          phase_nxt = PH_DC_TAG;
        end
        PH_OBJ: begin
          p_valid     = 1'b1;
          p_res.kind  = esdp_pkg::KIND_OBJ_TYPE;
          p_res.value = {20'd0, in_byte};
          skip_nxt    = '0;
          phase_nxt   = PH_SKIP;
        end
        PH_SKIP: begin
          if (skip_r >= esdp_pkg::SKIP_LAST) begin
            skip_nxt  = '0;
            phase_nxt = PH_DSI_TAG;
          end else begin
            skip_nxt = skip_r + 4'd1;
          end
        end
        PH_INFO: begin
          info_nxt    = info_r - 28'd1;
          p_valid     = 1'b1;
          p_res.kind  = esdp_pkg::KIND_INFO_BYTE;
          p_res.value = {20'd0, in_byte};
          // remaining count reaches zero on this byte
          if (info_r == 28'd1) begin
            p_res.last = 1'b1;
            fin_nxt    = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_ES_TAG;
        end
      endcase
    end

    // end of data: report truncation unless parsing finished, then start over
    e_valid = in_end_of_data && !fin_nxt;
    if (in_end_of_data) begin
      phase_nxt    = PH_ES_TAG;
      size_nxt     = '0;
      size_cnt_nxt = '0;
      flags_nxt    = '0;
      hold_nxt     = '0;
      skip_nxt     = '0;
      info_nxt     = '0;
      fin_nxt      = 1'b0;
    end
  end

  always_comb begin
    e_res.kind  = esdp_pkg::KIND_ERROR;
    e_res.value = esdp_pkg::ERR_TRUNCATED;
    e_res.last  = 1'b1;
    push          = take && (p_valid || e_valid);
    push_grp.pair = p_valid && e_valid;
    push_grp.r0   = p_valid ? p_res : e_res;
    push_grp.r1   = e_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ES_TAG;
      size_r     <= '0;
      size_cnt_r <= '0;
      flags_r    <= '0;
      hold_r     <= '0;
      skip_r     <= '0;
      info_r     <= '0;
      fin_r      <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      size_r     <= size_nxt;
      size_cnt_r <= size_cnt_nxt;
      flags_r    <= flags_nxt;
      hold_r     <= hold_nxt;
      skip_r     <= skip_nxt;
      info_r     <= info_nxt;
      fin_r      <= fin_nxt;
    end
  end

endmodule

FILE: rtl/esdp_res_queue.sv
// result queue: each entry holds the one or two results of a request
// depends on esdp_pkg
`timescale 1ns / 1ps

module esdp_res_queue #(
  parameter int unsigned DEPTH = esdp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esdp_pkg::grp_t  push_grp,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output esdp_pkg::res_t  out_res
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  esdp_pkg::grp_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           sel_r, sel_nxt;
  esdp_pkg::grp_t head;
  logic           pop_one;
  logic           grp_done;

  assign head      = mem_r[rd_ptr_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_res   = sel_r ? head.r1 : head.r0;
  assign pop_one   = out_valid && !out_stall;
  assign grp_done  = pop_one && (sel_r || !head.pair);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    sel_nxt    = sel_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (grp_done) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      sel_nxt    = 1'b0;
    end else if (pop_one) begin
      sel_nxt = 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(grp_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sel_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_grp;
  end

endmodule

FILE: rtl/es_descriptor_parser.sv
// top level of the es descriptor parser
// depends on esdp_pkg, esdp_core and esdp_res_queue
//
// usage
//   input channel: one descriptor byte per request (in_byte, in_end_of_data),
//   accepted on a rising edge with in_valid high and in_stall low
//   result channel: out_kind / out_value / out_last, taken on a rising edge
//   with out_valid high and out_stall low
//   config port: cfg_we writes cfg_wdata into tag register cfg_index
//   (es, decoder config, specific info); index 3 is ignored; write only idle
// timing
//   a request is parsed in the cycle it is accepted; its results are registered
//   in the result queue and show on the output from there
//   one byte per cycle sustained while in_stall is low; a byte causing two results
//   (last byte plus truncation error) puts them on the output one after the other
//   in_stall rises only when the result queue (QUEUE_DEPTH groups) is full
// reset
//   synchronous rst_n clears the parser to "expect es tag", empties the
//   queue and loads the default tags 3, 4, 5
// stall
//   a stalled result holds on the outputs; bytes keep flowing until the
//   queue fills
`timescale 1ns / 1ps

module es_descriptor_parser #(
  parameter int unsigned QUEUE_DEPTH = esdp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_data,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [27:0] out_value,
  output logic        out_last,
  // tag registers
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  esdp_pkg::tags_t tags_r;
  esdp_pkg::grp_t  push_grp;
  esdp_pkg::res_t  out_res;
  logic            take;
  logic            push;
  logic            full;

  // tag registers, plain writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tags_r.es  <= esdp_pkg::RST_ES_TAG;
      tags_r.dc  <= esdp_pkg::RST_DC_TAG;
      tags_r.dsi <= esdp_pkg::RST_DSI_TAG;
    end else if (cfg_we) begin
      case (cfg_index)
        esdp_pkg::REG_ES_TAG:  tags_r.es  <= cfg_wdata;
        esdp_pkg::REG_DC_TAG:  tags_r.dc  <= cfg_wdata;
        esdp_pkg::REG_DSI_TAG: tags_r.dsi <= cfg_wdata;
        default: ;  // unused index
      endcase
    end
  end

  // stall depends only on queue fill, never on in_valid
  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  esdp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .tags           (tags_r),
    .push           (push),
    .push_grp       (push_grp)
  );

  // result registers between parser and receiver
  esdp_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_grp  (push_grp),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind  = out_res.kind;
  assign out_value = out_res.value;
  assign out_last  = out_res.last;

endmodule

FILE: rtl/esdp_checker.sv
// port-level checks of the es descriptor parser, bound to the top level
// depends on esdp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [27:0] out_value,
  input logic        out_last
);

  `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall,
    $stable(out_kind) && $stable(out_value) && $stable(out_last), "stalled result changed")
  `ASSERT_IMPLY(a_err_last, clk, rst_n, out_valid && out_kind == esdp_pkg::KIND_ERROR,
    out_last && out_value <= esdp_pkg::ERR_TRUNCATED, "error result malformed")
  `ASSERT_IMPLY(a_id_narrow, clk, rst_n, out_valid && out_kind == esdp_pkg::KIND_STREAM_ID,
    !out_last && out_value[27:16] == 12'd0, "stream id result malformed")

endmodule

bind es_descriptor_parser esdp_checker u_esdp_checker (.*);
